/* sv/bc64_pkg.sv */
// shared types, constants and alphabet functions for the blowcrypt base64 codec
`timescale 1ns / 1ps
package bc64_pkg;

	localparam int unsigned QueueDepthDefault = 2;
	localparam int unsigned BytesPerBlock = 8;
	localparam int unsigned CharsPerBlock = 12;
	localparam int unsigned CharsPerWord = 6;

	localparam logic DirEncode = 1'b0;
	localparam logic DirDecode = 1'b1;

	typedef struct packed {
		logic [7:0] in_value;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_value;
		logic       run_last;
		logic       stream_end;
	} out_t;

	// one finished block handed from front to back
	typedef struct packed {
		logic [63:0] bits;
		logic        mode;
		logic        last;
	} desc_t;

	typedef struct packed {
		logic busy;
		logic holding;
	} back_stat_t;

	function automatic logic [7:0] alpha_char(input logic [5:0] idx);
		logic [7:0] i8;
		i8 = {2'b00, idx};
		if (idx == 6'd0) return 8'h2e;
		else if (idx == 6'd1) return 8'h2f;
		else if (idx < 6'd12) return 8'h30 + i8 - 8'd2;
		else if (idx < 6'd38) return 8'h61 + i8 - 8'd12;
		else return 8'h41 + i8 - 8'd38;
	endfunction

	function automatic logic [5:0] char_val(input logic [7:0] c);
		if (c == 8'h2e) return 6'd0;
		else if (c == 8'h2f) return 6'd1;
		else if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'd2);
		else if (c >= 8'h61 && c <= 8'h7a) return 6'(c - 8'h61 + 8'd12);
		else if (c >= 8'h41 && c <= 8'h5a) return 6'(c - 8'h41 + 8'd38);
		else return 6'd0;
	endfunction

endpackage

/* sv/bc64_front.sv */
// front end: takes input words, collects blocks, hands finished blocks to the queue
`timescale 1ns / 1ps
module bc64_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_dir,
	input  logic             accept,
	input  bc64_pkg::in_t    din,
	output logic             q_push,
	output bc64_pkg::desc_t  q_desc
);

	logic        dir_q;
	logic [63:0] bits_q;
	logic [3:0]  count_q;

	logic [2:0]  ek;
	logic [63:0] enc_bits;
	logic [3:0]  dk;
	logic [2:0]  dsh;
	logic [31:0] ins;
	logic [63:0] dec_bits;
	logic [63:0] nxt_bits;
	logic [3:0]  nxt_count;
	logic        done;

	always_comb begin
		ek = count_q[2:0];
		enc_bits = bits_q | (64'(din.in_value) << {~ek, 3'b000});

		dk = (count_q >= 4'(bc64_pkg::CharsPerBlock)) ? 4'd0 : count_q;
		dsh = (dk < 4'(bc64_pkg::CharsPerWord)) ? dk[2:0] : 3'(dk - 4'(bc64_pkg::CharsPerWord));
		ins = 32'(bc64_pkg::char_val(din.in_value)) << (5'(dsh) * 5'd6);
		if (dk < 4'(bc64_pkg::CharsPerWord))
			dec_bits = {bits_q[63:32], bits_q[31:0] | ins};
		else
			dec_bits = {bits_q[63:32] | ins, bits_q[31:0]};

		if (dir_q == bc64_pkg::DirEncode) begin
			nxt_bits = enc_bits;
			nxt_count = {1'b0, ek} + 4'd1;
			done = (nxt_count >= 4'(bc64_pkg::BytesPerBlock)) || din.in_last;
		end else begin
			nxt_bits = dec_bits;
			nxt_count = dk + 4'd1;
			done = (nxt_count >= 4'(bc64_pkg::CharsPerBlock)) || din.in_last;
		end
		q_push = accept && done;
		q_desc.bits = nxt_bits;
		q_desc.mode = dir_q;
		q_desc.last = din.in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= bc64_pkg::DirEncode;
			bits_q <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			dir_q <= cfg_dir;
			bits_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (done) begin
				bits_q <= '0;
				count_q <= '0;
			end else begin
				bits_q <= nxt_bits;
				count_q <= nxt_count;
			end
		end
	end

endmodule

/* sv/bc64_queue.sv */
// short block queue between front and back
`timescale 1ns / 1ps
module bc64_queue #(
	parameter int unsigned DEPTH = bc64_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bc64_pkg::desc_t  wdata,
	input  logic             pop,
	output bc64_pkg::desc_t  rdata,
	output logic             q_full,
	output logic             q_empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bc64_pkg::desc_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign q_full = (cnt_q == CW'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* sv/bc64_back.sv */
// back end: serializes a block into characters or bytes through an output register
`timescale 1ns / 1ps
module bc64_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  bc64_pkg::desc_t      q_desc,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output bc64_pkg::out_t       dout,
	output bc64_pkg::back_stat_t stat
);

	logic        busy_q;
	logic [63:0] sr_q;
	logic        mode_q;
	logic        last_q;
	logic [3:0]  idx_q;
	logic        out_valid_q;
	bc64_pkg::out_t out_q;

	logic        out_ok;
	logic        adv;
	logic        final_w;
	logic        word_end;
	logic [5:0]  grp;
	bc64_pkg::out_t res;

	always_comb begin
		out_ok = !out_valid_q || pop;
		adv = busy_q && out_ok;
		word_end = (idx_q == 4'd5) || (idx_q == 4'd11);
		if (mode_q == bc64_pkg::DirEncode)
			final_w = (idx_q == 4'(bc64_pkg::CharsPerBlock - 1));
		else
			final_w = (idx_q == 4'(bc64_pkg::BytesPerBlock - 1));
		// top group of a word carries two bits only
		grp = word_end ? {4'b0000, sr_q[1:0]} : sr_q[5:0];
		res.out_value = (mode_q == bc64_pkg::DirEncode) ? bc64_pkg::alpha_char(grp)
			: sr_q[63:56];
		res.run_last = final_w;
		res.stream_end = final_w && last_q;
		q_pop = !q_empty && (!busy_q || (adv && final_w));
	end

	assign empty = !out_valid_q;
	assign dout = out_q;
	assign stat.busy = busy_q;
	assign stat.holding = out_valid_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sr_q <= q_desc.bits;
			mode_q <= q_desc.mode;
			last_q <= q_desc.last;
		end else if (adv) begin
			if (mode_q == bc64_pkg::DirEncode)
				sr_q <= word_end ? (sr_q >> 2) : (sr_q >> 6);
			else
				sr_q <= sr_q << 8;
		end
		if (adv) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (adv && final_w) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				idx_q <= idx_q + 4'd1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/blowcrypt_base64_codec_core.sv */
// top level of the blowcrypt base64 codec
// The codec takes one byte (encode) or one character (decode) per cycle while
// full is low; a finished block of eight bytes or twelve characters, or a
// shorter one closed by in_last and zero-padded, moves through a small block
// queue to a serializer that delivers one result word per cycle, while results
// are popped, through an output register. When encoding the serializer sets
// the rate: it gives twelve characters for eight bytes. When decoding the input
// side sets it at one character per cycle, and the serializer gives only eight
// bytes for twelve characters. A block closed early by in_last still yields
// twelve (encode) or eight (decode) output words. Write the direction register
// only while no results are pending; cfg_ready is high then, and a write drops
// any partly collected block.
`timescale 1ns / 1ps
module blowcrypt_base64_codec_core #(
	parameter int unsigned QUEUE_DEPTH = bc64_pkg::QueueDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  bc64_pkg::in_t   din,
	output logic            empty,
	input  logic            pop,
	output bc64_pkg::out_t  dout,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data
);

	logic                 accept;
	logic                 cfg_we;
	logic                 f_push;
	bc64_pkg::desc_t      f_desc;
	bc64_pkg::desc_t      b_desc;
	logic                 b_pop;
	logic                 q_full;
	logic                 q_empty;
	bc64_pkg::back_stat_t stat;

	assign full = q_full;
	assign accept = push && !q_full;
	assign cfg_ready = q_empty && !stat.busy && !stat.holding;
	assign cfg_we = cfg_valid && cfg_ready;

	bc64_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg_dir(cfg_data),
		.accept (accept),
		.din    (din),
		.q_push (f_push),
		.q_desc (f_desc)
	);

	bc64_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_desc),
		.pop    (b_pop),
		.rdata  (b_desc),
		.q_full (q_full),
		.q_empty(q_empty)
	);

	bc64_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_desc (b_desc),
		.q_pop  (b_pop),
		.pop    (pop),
		.empty  (empty),
		.dout   (dout),
		.stat   (stat)
	);

endmodule

/* sv/bc64_checker.sv */
// port-level checks for the blowcrypt base64 codec, bound to the top level
`timescale 1ns / 1ps
module bc64_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           empty,
	input logic           pop,
	input bc64_pkg::out_t dout,
	input logic           cfg_valid,
	input logic           cfg_ready
);

	// config is taken only with no result word waiting
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> empty)
		else $error("config taken while a result word waits");

	// end of stream is always the last word of its item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && dout.stream_end |-> dout.run_last)
		else $error("stream_end without run_last");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result word dropped without pop");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(dout))
		else $error("result word changed while stalled");

endmodule

bind blowcrypt_base64_codec_core bc64_checker u_bc64_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.dout     (dout),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
